// ===== hdl/triple_ema_rate_of_change_top_assert.svh =====
// assertion macros shared by the trix block
`ifndef TRIPLE_EMA_RATE_OF_CHANGE_TOP_ASSERT_SVH
`define TRIPLE_EMA_RATE_OF_CHANGE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TRIX_ASSERT_IMPLY(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRIX_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TRIX_ASSERT_IMPLY(name, clock, reset, ante, cons, msg)
`define TRIX_ASSERT_NEXT(name, clock, reset, ante, cons, msg)

`endif

`endif

// ===== hdl/trix_pkg.sv =====
`default_nettype none

package trix_pkg;

  // fixed point layout
  localparam int FRACTION_BITS = 24;
  localparam int PRICE_W       = 32;
  localparam int PRICE_SHIFT   = FRACTION_BITS - 16;
  localparam int AVG_W         = 16 + FRACTION_BITS;

  // period and smoothing factor
  localparam int PERIOD_W     = 11;
  localparam int PERIOD_RESET = 15;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = PERIOD_W'(1);
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(1024);
  localparam int ALPHA_W      = 17;
  localparam int ALPHA_NUM    = 131072;
  localparam int ALPHA_NUM_W  = 18;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET =
    ALPHA_W'((ALPHA_NUM + (PERIOD_RESET + 1) / 2) / (PERIOD_RESET + 1));

  // shared multiplier
  localparam int SCALE_W       = 23;
  localparam int PERCENT_SCALE = 6553600;
  localparam int PROD_W        = AVG_W + SCALE_W;
  localparam int STEP_SHIFT    = 16;
  localparam int ROUND_BIAS    = 32768;

  // shared divider
  localparam int QUO_W = 32;
  localparam int HI_W  = PROD_W - QUO_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [QUO_W:0] POS_LIMIT = {2'b00, {(QUO_W - 1){1'b1}}};
  localparam logic [QUO_W:0] NEG_LIMIT = {2'b01, {(QUO_W - 1){1'b0}}};
  localparam logic signed [PRICE_W-1:0] PERCENT_MAX = {1'b0, {(PRICE_W - 1){1'b1}}};
  localparam logic signed [PRICE_W-1:0] PERCENT_MIN = {1'b1, {(PRICE_W - 1){1'b0}}};

  typedef logic signed [AVG_W-1:0] avg_t;
  typedef logic [AVG_W-1:0]        mag_t;
  typedef logic [PROD_W-1:0]       prod_t;

  // which average of the cascade is being moved
  typedef enum logic [1:0] {
    EMA_FIRST  = 2'd0,
    EMA_SECOND = 2'd1,
    EMA_THIRD  = 2'd2
  } ema_sel_t;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_ALPHA  = 10'b0000000010,
    ST_DIFF   = 10'b0000000100,
    ST_MUL    = 10'b0000001000,
    ST_MOVE   = 10'b0000010000,
    ST_PREP   = 10'b0000100000,
    ST_SCALE  = 10'b0001000000,
    ST_CHECK  = 10'b0010000000,
    ST_DIVIDE = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/trix_sample_if.sv =====
`default_nettype none

interface trix_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [trix_pkg::PRICE_W-1:0]   close_price;

  modport source (output valid, output close_price, input ready);
  modport sink   (input valid, input close_price, output ready);
endinterface

`default_nettype wire

// ===== hdl/trix_result_if.sv =====
`default_nettype none

interface trix_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [trix_pkg::PRICE_W-1:0]   trix_percent;
  logic                                  first_sample;
  logic                                  saturated;

  modport source (output valid, output trix_percent, output first_sample,
                  output saturated, input ready);
  modport sink   (input valid, input trix_percent, input first_sample,
                  input saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/trix_cfg_if.sv =====
`default_nettype none

interface trix_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [trix_pkg::PERIOD_W-1:0]     smoothing_period;

  modport source (output valid, output smoothing_period, input ready);
  modport sink   (input valid, input smoothing_period, output ready);
endinterface

`default_nettype wire

// ===== hdl/triple_ema_rate_of_change_top.sv =====
`default_nettype none

// TRIX oscillator: each price word (signed Q16.16) moves a cascade of three
// exponential averages by a factor 2/(n+1), and the block returns 100 times the
// relative change of the third average as a signed Q16.16 word, rounded and
// clipped, with a flag when clipped. The first word after reset seeds all three
// averages and returns 0 with first_sample set; a previous third average of zero
// also returns 0. One word at a time. A seeding word goes straight to the
// output register, a word with a zero previous average skips the scaling and
// the division, a quotient that would reach 2^32 is clipped at once without
// dividing, and a normal word runs the three average steps, the scaling and the
// division; the sample side is ready again from the edge that loads the output
// register. The sequencer uses one shared multiplier for the three average steps
// and the percent scaling, and a one-bit-a-cycle restoring divider that runs 32
// steps for the quotient. If the output register is still full, the sequencer
// waits until the word is taken. Writing smoothing_period reuses that divider for
// the factor, keeping the sample side not ready in the write cycle and while the
// factor is divided; a period is taken only between words, a new period applies
// from the next word and the averages are kept. A finished result sits in an
// output register, so the next word is taken while it waits.

`include "triple_ema_rate_of_change_top_assert.svh"

module triple_ema_rate_of_change_top (
  input  logic          clk,
  input  logic          rst,
  trix_sample_if.sink   sample,
  trix_result_if.source result,
  trix_cfg_if.sink      cfg
);

  trix_pkg::state_t   state;
  trix_pkg::ema_sel_t ema_idx;
  logic               seeded;

  // smoothing factor in Q1.16
  logic [trix_pkg::ALPHA_W-1:0] alpha;

  // averages, the sample and the third average before this word
  trix_pkg::avg_t first_avg, second_avg, third_avg;
  trix_pkg::avg_t price;
  trix_pkg::avg_t prev;

  // shared datapath registers
  trix_pkg::mag_t  mag;
  trix_pkg::mag_t  pmag;
  logic            neg;
  trix_pkg::prod_t prod;

  // divider
  trix_pkg::mag_t                 div_rem;
  trix_pkg::mag_t                 div_den;
  logic [trix_pkg::QUO_W-1:0]     div_num;
  logic [trix_pkg::QUO_W-1:0]     div_quo;
  logic [trix_pkg::CNT_W-1:0]     div_cnt;

  // staged result and output register
  logic signed [trix_pkg::PRICE_W-1:0] res_value;
  logic                                res_first;
  logic                                res_sat;
  logic                                out_valid;
  logic signed [trix_pkg::PRICE_W-1:0] out_percent;
  logic                                out_first;
  logic                                out_sat;

  // combinational
  logic                             accept;
  logic                             out_free;
  trix_pkg::avg_t                   x_ext;
  trix_pkg::avg_t                   avg_cur;
  trix_pkg::avg_t                   tgt;
  logic signed [trix_pkg::AVG_W:0]  ema_diff;
  logic signed [trix_pkg::AVG_W:0]  ema_diff_neg;
  logic                             ema_down;
  trix_pkg::mag_t                   ema_mag;
  trix_pkg::prod_t                  step_sum;
  trix_pkg::mag_t                   step_val;
  trix_pkg::avg_t                   avg_moved;
  logic signed [trix_pkg::AVG_W:0]  t_diff;
  logic signed [trix_pkg::AVG_W:0]  t_diff_neg;
  logic signed [trix_pkg::AVG_W:0]  prev_neg;
  trix_pkg::mag_t                   mul_a;
  logic [trix_pkg::SCALE_W-1:0]     mul_b;
  trix_pkg::prod_t                  mul_out;
  logic [trix_pkg::HI_W-1:0]        prod_hi;
  logic                             big;
  logic [trix_pkg::AVG_W:0]         shifted;
  logic [trix_pkg::AVG_W:0]         sub;
  logic                             fits;
  trix_pkg::mag_t                   rem_step;
  logic                             round_up;
  logic [trix_pkg::QUO_W:0]         q_round;
  logic [trix_pkg::QUO_W:0]         q_neg;
  logic [trix_pkg::PERIOD_W-1:0]    p_clamp;
  logic [trix_pkg::PERIOD_W-1:0]    alpha_den;
  logic [trix_pkg::ALPHA_NUM_W-1:0] alpha_num;

  // configuration always wins over a sample in the same cycle
  assign sample.ready = (state == trix_pkg::ST_IDLE) && !cfg.valid;
  // a period is only taken between words
  assign cfg.ready    = (state == trix_pkg::ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !out_valid || result.ready;

  assign result.valid        = out_valid;
  assign result.trix_percent = out_percent;
  assign result.first_sample = out_first;
  assign result.saturated    = out_sat;

  // price in average format
  assign x_ext = trix_pkg::avg_t'(sample.close_price) <<< trix_pkg::PRICE_SHIFT;

  // period clamped, factor numerator rounded to nearest
  always_comb begin
    if (cfg.smoothing_period < trix_pkg::PERIOD_MIN) begin
      p_clamp = trix_pkg::PERIOD_MIN;
    end else if (cfg.smoothing_period > trix_pkg::PERIOD_MAX) begin
      p_clamp = trix_pkg::PERIOD_MAX;
    end else begin
      p_clamp = cfg.smoothing_period;
    end
    alpha_den = p_clamp + trix_pkg::PERIOD_W'(1);
    alpha_num = trix_pkg::ALPHA_NUM_W'(trix_pkg::ALPHA_NUM)
              + trix_pkg::ALPHA_NUM_W'(alpha_den >> 1);
  end

  // average being moved and its target
  always_comb begin
    case (ema_idx)
      trix_pkg::EMA_FIRST: begin
        avg_cur = first_avg;
        tgt     = price;
      end
      trix_pkg::EMA_SECOND: begin
        avg_cur = second_avg;
        tgt     = first_avg;
      end
      default: begin
        avg_cur = third_avg;
        tgt     = second_avg;
      end
    endcase
  end

  // distance to target as sign and magnitude
  always_comb begin
    ema_diff     = {tgt[trix_pkg::AVG_W-1], tgt} - {avg_cur[trix_pkg::AVG_W-1], avg_cur};
    ema_diff_neg = -ema_diff;
    ema_down     = ema_diff[trix_pkg::AVG_W];
    ema_mag      = ema_down ? ema_diff_neg[trix_pkg::AVG_W-1:0]
                            : ema_diff[trix_pkg::AVG_W-1:0];
  end

  // rounded step, ties away from zero since it is applied by sign
  always_comb begin
    step_sum  = prod + trix_pkg::PROD_W'(trix_pkg::ROUND_BIAS);
    step_val  = step_sum[trix_pkg::STEP_SHIFT +: trix_pkg::AVG_W];
    avg_moved = neg ? (avg_cur - trix_pkg::avg_t'(step_val))
                    : (avg_cur + trix_pkg::avg_t'(step_val));
  end

  // change of the third average and magnitude of the old one
  always_comb begin
    t_diff     = {third_avg[trix_pkg::AVG_W-1], third_avg} - {prev[trix_pkg::AVG_W-1], prev};
    t_diff_neg = -t_diff;
    prev_neg   = -{prev[trix_pkg::AVG_W-1], prev};
  end

  // the one multiplier
  always_comb begin
    if (state == trix_pkg::ST_SCALE) begin
      mul_a = mag;
      mul_b = trix_pkg::SCALE_W'(trix_pkg::PERCENT_SCALE);
    end else begin
      mul_a = mag;
      mul_b = trix_pkg::SCALE_W'(alpha);
    end
    mul_out = trix_pkg::PROD_W'(mul_a) * trix_pkg::PROD_W'(mul_b);
  end

  // quotient would reach 2^32: clip straight away
  assign prod_hi = prod[trix_pkg::PROD_W-1:trix_pkg::QUO_W];
  assign big     = trix_pkg::AVG_W'(prod_hi) >= pmag;

  // restoring divider step and final rounding
  always_comb begin
    shifted  = {div_rem, div_num[trix_pkg::QUO_W-1]};
    sub      = shifted - {1'b0, div_den};
    fits     = shifted >= {1'b0, div_den};
    rem_step = fits ? sub[trix_pkg::AVG_W-1:0] : shifted[trix_pkg::AVG_W-1:0];
    round_up = {div_rem, 1'b0} >= {1'b0, div_den};
    q_round  = {1'b0, div_quo} + (trix_pkg::QUO_W + 1)'(round_up);
    q_neg    = (trix_pkg::QUO_W + 1)'(0) - q_round;
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= trix_pkg::ST_IDLE;
      seeded     <= 1'b0;
      alpha      <= trix_pkg::ALPHA_RESET;
      first_avg  <= '0;
      second_avg <= '0;
      third_avg  <= '0;
      ema_idx    <= trix_pkg::EMA_FIRST;
    end else begin
      case (state)
        trix_pkg::ST_IDLE: begin
          if (cfg.valid) begin
            // factor = (2^17 + (n+1)/2) / (n+1) on the shared divider
            div_rem <= '0;
            div_num <= {alpha_num, {(trix_pkg::QUO_W - trix_pkg::ALPHA_NUM_W){1'b0}}};
            div_den <= trix_pkg::AVG_W'(alpha_den);
            div_quo <= '0;
            div_cnt <= trix_pkg::CNT_W'(trix_pkg::ALPHA_NUM_W);
            state   <= trix_pkg::ST_ALPHA;
          end else if (accept) begin
            res_value <= '0;
            res_sat   <= 1'b0;
            if (!seeded) begin
              first_avg  <= x_ext;
              second_avg <= x_ext;
              third_avg  <= x_ext;
              seeded     <= 1'b1;
              res_first  <= 1'b1;
              state      <= trix_pkg::ST_EMIT;
            end else begin
              price     <= x_ext;
              prev      <= third_avg;
              res_first <= 1'b0;
              ema_idx   <= trix_pkg::EMA_FIRST;
              state     <= trix_pkg::ST_DIFF;
            end
          end
        end
        trix_pkg::ST_ALPHA: begin
          if (div_cnt == '0) begin
            alpha <= div_quo[trix_pkg::ALPHA_W-1:0];
            state <= trix_pkg::ST_IDLE;
          end else begin
            div_rem <= rem_step;
            div_num <= div_num << 1;
            div_quo <= {div_quo[trix_pkg::QUO_W-2:0], fits};
            div_cnt <= div_cnt - trix_pkg::CNT_W'(1);
          end
        end
        trix_pkg::ST_DIFF: begin
          mag   <= ema_mag;
          neg   <= ema_down;
          state <= trix_pkg::ST_MUL;
        end
        trix_pkg::ST_MUL: begin
          prod  <= mul_out;
          state <= trix_pkg::ST_MOVE;
        end
        trix_pkg::ST_MOVE: begin
          case (ema_idx)
            trix_pkg::EMA_FIRST: begin
              first_avg <= avg_moved;
              ema_idx   <= trix_pkg::EMA_SECOND;
              state     <= trix_pkg::ST_DIFF;
            end
            trix_pkg::EMA_SECOND: begin
              second_avg <= avg_moved;
              ema_idx    <= trix_pkg::EMA_THIRD;
              state      <= trix_pkg::ST_DIFF;
            end
            default: begin
              third_avg <= avg_moved;
              ema_idx   <= trix_pkg::EMA_FIRST;
              state     <= trix_pkg::ST_PREP;
            end
          endcase
        end
        trix_pkg::ST_PREP: begin
          mag  <= t_diff[trix_pkg::AVG_W] ? t_diff_neg[trix_pkg::AVG_W-1:0]
                                          : t_diff[trix_pkg::AVG_W-1:0];
          pmag <= prev[trix_pkg::AVG_W-1] ? prev_neg[trix_pkg::AVG_W-1:0] : prev;
          neg  <= t_diff[trix_pkg::AVG_W] ^ prev[trix_pkg::AVG_W-1];
          // a zero old average gives zero
          if (prev == '0) begin
            state <= trix_pkg::ST_EMIT;
          end else begin
            state <= trix_pkg::ST_SCALE;
          end
        end
        trix_pkg::ST_SCALE: begin
          prod  <= mul_out;
          state <= trix_pkg::ST_CHECK;
        end
        trix_pkg::ST_CHECK: begin
          if (big) begin
            res_sat   <= 1'b1;
            res_value <= neg ? trix_pkg::PERCENT_MIN : trix_pkg::PERCENT_MAX;
            state     <= trix_pkg::ST_EMIT;
          end else begin
            div_rem <= trix_pkg::AVG_W'(prod_hi);
            div_num <= prod[trix_pkg::QUO_W-1:0];
            div_den <= pmag;
            div_quo <= '0;
            div_cnt <= trix_pkg::CNT_W'(trix_pkg::QUO_W);
            state   <= trix_pkg::ST_DIVIDE;
          end
        end
        trix_pkg::ST_DIVIDE: begin
          if (div_cnt == '0) begin
            if (neg) begin
              if (q_round > trix_pkg::NEG_LIMIT) begin
                res_sat   <= 1'b1;
                res_value <= trix_pkg::PERCENT_MIN;
              end else begin
                res_value <= q_neg[trix_pkg::QUO_W-1:0];
              end
            end else begin
              if (q_round > trix_pkg::POS_LIMIT) begin
                res_sat   <= 1'b1;
                res_value <= trix_pkg::PERCENT_MAX;
              end else begin
                res_value <= q_round[trix_pkg::QUO_W-1:0];
              end
            end
            state <= trix_pkg::ST_EMIT;
          end else begin
            div_rem <= rem_step;
            div_num <= div_num << 1;
            div_quo <= {div_quo[trix_pkg::QUO_W-2:0], fits};
            div_cnt <= div_cnt - trix_pkg::CNT_W'(1);
          end
        end
        trix_pkg::ST_EMIT: begin
          // wait here only while the output register is still full
          if (out_free) begin
            state <= trix_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= trix_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == trix_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == trix_pkg::ST_EMIT && out_free) begin
      out_percent <= res_value;
      out_first   <= res_first;
      out_sat     <= res_sat;
    end
  end

  // the sample side is not ready in the cycle after a taken word
  `TRIX_ASSERT_NEXT(a_busy_after_word, clk, rst, sample.valid && sample.ready, !sample.ready, "sample side ready right after a word")

  // a seeding word always reads zero and unclipped
  `TRIX_ASSERT_IMPLY(a_seed_zero, clk, rst, result.valid && result.first_sample, result.trix_percent == '0 && !result.saturated, "seeding word not zero")

  // clipping lands on one of the two limits
  `TRIX_ASSERT_IMPLY(a_sat_limit, clk, rst, result.valid && result.saturated, result.trix_percent == trix_pkg::PERCENT_MAX || result.trix_percent == trix_pkg::PERCENT_MIN, "clipped word off limit")

  // a staged result is handed over and the sequencer goes idle
  `TRIX_ASSERT_NEXT(a_emit_loads, clk, rst, state == trix_pkg::ST_EMIT && out_free, result.valid && state == trix_pkg::ST_IDLE, "staged result not loaded")

endmodule

`default_nettype wire

// ===== bench/tb_triple_ema_rate_of_change_top.sv =====
module tb_triple_ema_rate_of_change_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one result word as it leaves the block
  typedef struct packed {
    logic signed [trix_pkg::PRICE_W-1:0] trix_percent;
    logic                                first_sample;
    logic                                saturated;
  } trix_word_t;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 600;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned RANDOM_RUNS = 7;
  localparam int unsigned RUN_WORDS   = 150;
  localparam int unsigned SHOW_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // bench side of the three channels, known from time zero
  logic                                send_valid = 1'b0;
  logic signed [trix_pkg::PRICE_W-1:0] send_price = '0;
  logic                                take_ready = 1'b0;
  logic                                cfg_valid  = 1'b0;
  logic [trix_pkg::PERIOD_W-1:0]       cfg_period = '0;

  trix_sample_if sample_bus ();
  trix_result_if result_bus ();
  trix_cfg_if    cfg_bus ();

  assign sample_bus.valid       = send_valid;
  assign sample_bus.close_price = send_price;
  assign result_bus.ready       = take_ready;
  assign cfg_bus.valid          = cfg_valid;
  assign cfg_bus.smoothing_period = cfg_period;

  triple_ema_rate_of_change_top DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #2 clk = ~clk;

  // price words still to be offered, and results the block owes us
  logic signed [trix_pkg::PRICE_W-1:0] price_queue[$];
  trix_word_t                          trix_expected[$];

  // shadow of the block: period register and the three cascaded averages
  logic [trix_pkg::PERIOD_W-1:0] period_reg = trix_pkg::PERIOD_W'(trix_pkg::PERIOD_RESET);
  trix_pkg::avg_t                fast_avg   = '0;
  trix_pkg::avg_t                mid_avg    = '0;
  trix_pkg::avg_t                slow_avg   = '0;
  logic                          seeded     = 1'b0;

  // pacing of both sides
  logic        calm          = 1'b0;
  int unsigned send_gap      = 0;
  int unsigned take_gap      = 0;
  int unsigned hold_left     = 0;
  logic        long_hold_done = 1'b0;
  int unsigned results_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;
  longint      walk_price    = 0;

  // smoothing factor in Q1.16: 2/(n+1) rounded, period clipped to 1..1024
  function automatic int unsigned alpha_of(logic [trix_pkg::PERIOD_W-1:0] period);
    int unsigned p;
    p = 32'(period);
    if (period < trix_pkg::PERIOD_MIN) p = 32'(trix_pkg::PERIOD_MIN);
    if (period > trix_pkg::PERIOD_MAX) p = 32'(trix_pkg::PERIOD_MAX);
    return (trix_pkg::ALPHA_NUM + (p + 1) / 2) / (p + 1);
  endfunction

  // move one average towards its target; step magnitude rounded half away from zero
  function automatic trix_pkg::avg_t ema_step(trix_pkg::avg_t level, trix_pkg::avg_t target,
                                              int unsigned alpha);
    longint a, t, distance, move;
    a = longint'(level);
    t = longint'(target);
    distance = (t < a) ? a - t : t - a;
    move = (distance * longint'(alpha) + longint'(trix_pkg::ROUND_BIAS))
           >>> trix_pkg::STEP_SHIFT;
    return (t < a) ? trix_pkg::avg_t'(a - move) : trix_pkg::avg_t'(a + move);
  endfunction

  // 100 * (now - prev) / prev in Q16.16, rounded and clipped
  function automatic trix_word_t percent_of(trix_pkg::avg_t prev, trix_pkg::avg_t now);
    longint     d, p;
    logic [127:0] num, den, quo, rem;
    trix_word_t w;
    w = '0;
    d = longint'(now) - longint'(prev);
    p = longint'(prev);
    // a zero previous average or no movement both give a plain zero
    if (p == 0 || d == 0) return w;
    num = 128'(d < 0 ? -d : d) * 128'(trix_pkg::PERCENT_SCALE);
    den = 128'(p < 0 ? -p : p);
    quo = num / den;
    rem = num - quo * den;
    if (2 * rem >= den) quo = quo + 1;
    if ((d < 0) != (p < 0)) begin
      if (quo > 128'(trix_pkg::NEG_LIMIT)) begin
        quo = 128'(trix_pkg::NEG_LIMIT);
        w.saturated = 1'b1;
      end
      w.trix_percent = trix_pkg::PRICE_W'(-quo);
    end else begin
      if (quo > 128'(trix_pkg::POS_LIMIT)) begin
        quo = 128'(trix_pkg::POS_LIMIT);
        w.saturated = 1'b1;
      end
      w.trix_percent = trix_pkg::PRICE_W'(quo);
    end
    return w;
  endfunction

  // advance the shadow cascade by one accepted price word
  function automatic void predict_sample(logic signed [trix_pkg::PRICE_W-1:0] price);
    trix_pkg::avg_t x, prev;
    int unsigned    alpha;
    trix_word_t     w;
    x = trix_pkg::avg_t'(price) <<< trix_pkg::PRICE_SHIFT;
    if (!seeded) begin
      // seeding word loads all three averages
      fast_avg = x;
      mid_avg  = x;
      slow_avg = x;
      seeded   = 1'b1;
      w = '0;
      w.first_sample = 1'b1;
    end else begin
      alpha    = alpha_of(period_reg);
      prev     = slow_avg;
      fast_avg = ema_step(fast_avg, x, alpha);
      mid_avg  = ema_step(mid_avg, fast_avg, alpha);
      slow_avg = ema_step(slow_avg, mid_avg, alpha);
      w = percent_of(prev, slow_avg);
    end
    trix_expected.push_back(w);
  endfunction

  function automatic void note_mismatch(string what, trix_word_t want, trix_word_t got);
    mismatch_count++;
    if (mismatch_count <= SHOW_LIMIT)
      $display("%s at result %0d: want %0d first %b sat %b, got %0d first %b sat %b",
               what, results_seen, want.trix_percent, want.first_sample, want.saturated,
               got.trix_percent, got.first_sample, got.saturated);
  endfunction

  // random price: mostly a walk around a base, some noise and extremes
  function automatic logic [trix_pkg::PRICE_W-1:0] next_price();
    int unsigned mode, span;
    longint      stride;
    mode = $urandom_range(0, 19);
    if (mode == 0) return $urandom;
    if (mode == 1) begin
      case ($urandom_range(0, 3))
        0:       return 32'h7FFF_FFFF;
        1:       return 32'h8000_0000;
        2:       return '0;
        default: return trix_pkg::PRICE_W'($urandom_range(0, 3));
      endcase
    end
    span   = $urandom_range(2, 20);
    stride = longint'($urandom_range(0, 1 << span)) - longint'(1 << (span - 1));
    walk_price = walk_price + stride;
    if (walk_price > 64'sd2147483647) walk_price = 64'sd2147483647;
    if (walk_price < -64'sd2147483648) walk_price = -64'sd2147483648;
    return trix_pkg::PRICE_W'(walk_price);
  endfunction

  // sample driver: offers queued words, idles in bursts unless calm
  always @(posedge clk) begin
    if (rst) begin
      send_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      // word taken at this edge: update the shadow
      if (send_valid && sample_bus.ready) predict_sample(send_price);
      if (!send_valid || sample_bus.ready) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          send_valid <= 1'b0;
        end else if (price_queue.size() != 0) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap   <= $urandom_range(0, 18);
            send_valid <= 1'b0;
          end else begin
            send_valid <= 1'b1;
            send_price <= price_queue.pop_front();
          end
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  // result ready: short random stalls, one long hold to back the block up
  always @(posedge clk) begin
    if (rst) begin
      take_ready <= 1'b0;
      take_gap   <= 0;
      hold_left  <= 0;
    end else if (!long_hold_done && results_seen == HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= LONG_HOLD;
      take_ready     <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      take_ready <= 1'b0;
    end else if (take_gap != 0) begin
      take_gap   <= take_gap - 1;
      take_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      take_gap   <= $urandom_range(0, 18);
      take_ready <= 1'b0;
    end else begin
      take_ready <= 1'b1;
    end
  end

  // result monitor: every accepted word against the oldest prediction
  always @(posedge clk) begin : watch_results
    trix_word_t got, want;
    if (!rst && result_bus.valid && take_ready) begin
      got.trix_percent = result_bus.trix_percent;
      got.first_sample = result_bus.first_sample;
      got.saturated    = result_bus.saturated;
      results_seen <= results_seen + 1;
      if (trix_expected.size() == 0) begin
        note_mismatch("unexpected word", '0, got);
      end else begin
        want = trix_expected.pop_front();
        if (got.trix_percent !== want.trix_percent || got.first_sample !== want.first_sample
            || got.saturated !== want.saturated)
          note_mismatch("wrong word", want, got);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[triple_ema_rate_of_change_top] ERROR");
    $finish;
  end

  // wait until every queued word is taken and every result is back
  task automatic drain();
    @(negedge clk);
    while (price_queue.size() != 0 || send_valid || trix_expected.size() != 0)
      @(negedge clk);
  endtask

  // period write, only with the block idle
  task automatic write_period(input logic [trix_pkg::PERIOD_W-1:0] value);
    @(posedge clk);
    cfg_valid  <= 1'b1;
    cfg_period <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    period_reg = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [trix_pkg::PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0, 1:    return trix_pkg::PERIOD_W'($urandom_range(1, 8));
      2:       return trix_pkg::PERIOD_W'($urandom_range(1025, 2047));
      3:       return '0;
      default: return trix_pkg::PERIOD_W'($urandom_range(1, 1024));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // power-on period: seed with zero, then a zero previous average, then extremes
    price_queue = '{32'sh0, 32'sh3039, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000};
    drain();

    // period 1: averages follow the price exactly, so clipping is easy to reach
    write_period(trix_pkg::PERIOD_W'(1));
    price_queue = '{32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh7FFF_FFFF,
                    32'sh0001_0000, 32'sh0001_0000, 32'sh0, 32'sh5};
    drain();

    // period 0 acts as 1
    write_period('0);
    price_queue = '{32'sh3, 32'shFFFF_0000};
    drain();

    // all-ones period acts as the top of the range
    write_period('1);
    price_queue = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678};
    drain();

    write_period(trix_pkg::PERIOD_MAX);
    price_queue = '{32'sh4000_0000};
    drain();

    // random runs, each under its own period; the last one without idling
    for (int unsigned run = 0; run < RANDOM_RUNS; run++) begin
      write_period(run == 0 ? trix_pkg::PERIOD_W'(2) : pick_period());
      if (run == RANDOM_RUNS - 1) calm = 1'b1;
      walk_price = longint'($signed($urandom)) >>> $urandom_range(0, 12);
      repeat (RUN_WORDS) price_queue.push_back(next_price());
      drain();
    end

    // settle past the block's latency, watching for stray words
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[triple_ema_rate_of_change_top] OK");
    end else begin
      $display("[triple_ema_rate_of_change_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== triple_ema_rate_of_change_top.f =====
+incdir+hdl
hdl/trix_pkg.sv
hdl/trix_sample_if.sv
hdl/trix_result_if.sv
hdl/trix_cfg_if.sv
hdl/triple_ema_rate_of_change_top.sv
bench/tb_triple_ema_rate_of_change_top.sv
